[hdl/rrte_pkg.sv]
// Package for the route table engine: sizes, operation codes, beat types
// and the state encoding. No dependencies.
`default_nettype none

package rrte_pkg;

    localparam int ROUTES = 32;
    localparam int PORTS  = 16;
    localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNT_W  = $clog2(ROUTES + 1);

    localparam logic [4:0] METRIC_INF  = 5'd16;
    localparam logic [7:0] AGE_MAX     = 8'd255;
    localparam logic [7:0] TIMEOUT_RST = 8'd20;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_RIP  = 3'd1;
    localparam logic [2:0] OP_LOOK = 3'd2;
    localparam logic [2:0] OP_CHG  = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;
    localparam logic [2:0] OP_ADV  = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [3:0]  port;
        logic [31:0] prefix;
        logic [31:0] netmask;
        logic [4:0]  hop_metric;
        logic [4:0]  link_cost;
        logic        link_up;
        logic        cost_moved;
        logic        entry_last;
    } t_item;

    typedef struct packed {
        logic        hit;
        logic [3:0]  out_port;
        logic [31:0] gateway;
        logic [31:0] route_prefix;
        logic [31:0] route_mask;
        logic [4:0]  route_metric;
        logic        final_res;
        logic        table_full;
    } t_res;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
        logic [4:0]  metric;
        logic [4:0]  link_cost;
        logic [7:0]  age;
        logic        fixed;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

[hdl/rip_route_table_engine.sv]
// Top level of the route table engine: sequencer, route memory and result register.
// Depends on rrte_pkg.
`default_nettype none

// The block holds a table of ROUTES routes. Valid bits live in flip-flops;
// all other route fields live in one synchronous memory, one route a word.
// Input beats arrive on i_valid/o_stall with the item in i_item; result
// beats leave on o_valid/i_stall with the result in o_res.
// Every item is handled by one scan over the memory, one route read per
// cycle unless a stalled advertise result holds the scan; the memory has
// a single read port. Add and RIP entry items find their slot during the
// scan and write it in a closing cycle; interface change and tick items
// rewrite each affected route in the cycle after reading it. Advertise
// items give one result beat per valid route during the scan when the
// port is in range, and a stalled receiver holds the scan in place.
// A new item is taken only when the previous one is finished, but a last
// result may still wait in the output register while the next item runs.
// Synchronous reset clears the valid bits, the packet change flag, the
// control state and sets garbage_timeout to 20; the memory is not cleared,
// since a route is only used while its valid bit is set. The user must write
// garbage_timeout through i_cfg_we/i_cfg_data only while idle; it is not enforced.
module rip_route_table_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire rrte_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_stall,
    output rrte_pkg::t_res      o_res,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_data
);
    import rrte_pkg::*;

    t_state              r_state, n_state;
    t_item               r_in, n_in;
    logic [31:0]         r_key, n_key;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_dv, n_dv;
    logic [IDX_W-1:0]    r_didx, n_didx;
    logic [ROUTES-1:0]   r_valid, n_valid;
    logic                r_match_f, n_match_f;
    logic [IDX_W-1:0]    r_match_i, n_match_i;
    t_entry              r_match_e, n_match_e;
    logic                r_free_f, n_free_f;
    logic [IDX_W-1:0]    r_free_i, n_free_i;
    logic                r_hit, n_hit;
    logic                r_found, n_found;
    logic [31:0]         r_best, n_best;
    logic [3:0]          r_port, n_port;
    logic [31:0]         r_gw, n_gw;
    logic                r_changed, n_changed;
    logic [7:0]          r_timeout;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    // Route memory.
    t_entry              mem [ROUTES];
    t_entry              r_rdata;
    logic                rd_en;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_idx[IDX_W-1:0]];
        end
    end

    logic              out_free;
    logic              port_ok;
    logic              v;
    logic              blocked;
    t_entry            e;
    t_entry            w;
    logic [7:0]        age_n;
    logic signed [6:0] m_s;
    logic [5:0]        sum;
    logic [4:0]        met;
    logic              chg;
    logic [ROUTES-1:0] above;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_key       = r_key;
        n_idx       = r_idx;
        n_dv        = r_dv;
        n_didx      = r_didx;
        n_valid     = r_valid;
        n_match_f   = r_match_f;
        n_match_i   = r_match_i;
        n_match_e   = r_match_e;
        n_free_f    = r_free_f;
        n_free_i    = r_free_i;
        n_hit       = r_hit;
        n_found     = r_found;
        n_best      = r_best;
        n_port      = r_port;
        n_gw        = r_gw;
        n_changed   = r_changed;
        n_out_valid = r_out_valid & i_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_didx;
        mem_wdata   = r_rdata;
        out_free    = !r_out_valid || !i_stall;
        port_ok     = {1'b0, r_in.port} < 5'(PORTS);
        e           = r_rdata;
        v           = r_valid[r_didx];
        blocked     = r_dv && (r_in.op == OP_ADV) && port_ok && v && !out_free;
        w           = r_rdata;
        age_n       = 8'd0;
        m_s         = 7'sd0;
        sum         = 6'({1'b0, r_in.hop_metric} + {1'b0, r_in.link_cost});
        met         = (sum > 6'(METRIC_INF)) ? METRIC_INF : sum[4:0];
        chg         = r_changed;
        above       = (r_valid >> r_didx) >> 1;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_in      = i_item;
                    n_key     = (i_item.op == OP_ADD) ? (i_item.prefix & i_item.netmask)
                                                      : i_item.prefix;
                    n_idx     = '0;
                    n_dv      = 1'b0;
                    n_match_f = 1'b0;
                    n_free_f  = 1'b0;
                    n_hit     = 1'b0;
                    n_found   = 1'b0;
                    n_best    = '0;
                    n_port    = '0;
                    n_gw      = '1;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == CNT_W'(ROUTES) && !r_dv) begin
                    n_state = (r_in.op == OP_ADV) ? ST_IDLE : ST_DONE;
                end else if (!blocked) begin
                    if (r_dv) begin
                        case (r_in.op)
                            OP_ADD, OP_RIP: begin
                                if (v && e.prefix == r_key && e.mask == r_in.netmask
                                    && !r_match_f) begin
                                    n_match_f = 1'b1;
                                    n_match_i = r_didx;
                                    n_match_e = e;
                                end
                                if (!v && !r_free_f) begin
                                    n_free_f = 1'b1;
                                    n_free_i = r_didx;
                                end
                            end
                            OP_LOOK: begin
                                if (v && e.metric < METRIC_INF
                                    && ((r_in.addr ^ e.prefix) & e.mask) == 32'd0
                                    && (!r_found || e.mask > r_best)) begin
                                    n_found = 1'b1;
                                    n_best  = e.mask;
                                    n_port  = e.port;
                                    n_gw    = e.gateway;
                                end
                            end
                            OP_CHG: begin
                                if (port_ok && v && e.port == r_in.port) begin
                                    n_hit = 1'b1;
                                    if (!r_in.link_up) begin
                                        n_valid[r_didx] = 1'b0;
                                    end else if (r_in.cost_moved) begin
                                        m_s = $signed({2'b00, e.metric})
                                            - $signed({2'b00, e.link_cost})
                                            + $signed({2'b00, r_in.link_cost});
                                        w.link_cost = r_in.link_cost;
                                        if (m_s < 7'sd0) begin
                                            w.metric = 5'd0;
                                        end else if (m_s > $signed({2'b00, METRIC_INF})) begin
                                            w.metric = METRIC_INF;
                                        end else begin
                                            w.metric = m_s[4:0];
                                        end
                                        mem_we    = 1'b1;
                                        mem_wdata = w;
                                    end
                                end
                            end
                            OP_TICK: begin
                                if (v && !e.fixed) begin
                                    age_n     = (e.age < AGE_MAX) ? e.age + 8'd1 : e.age;
                                    w.age     = age_n;
                                    mem_we    = 1'b1;
                                    mem_wdata = w;
                                    if (age_n >= r_timeout) begin
                                        n_valid[r_didx] = 1'b0;
                                        n_hit           = 1'b1;
                                    end
                                end
                            end
                            OP_ADV: begin
                                if (port_ok && v) begin
                                    n_out_valid        = 1'b1;
                                    n_out              = '0;
                                    n_out.hit          = 1'b1;
                                    n_out.out_port     = e.port;
                                    n_out.gateway      = e.gateway;
                                    n_out.route_prefix = e.prefix;
                                    n_out.route_mask   = e.mask;
                                    n_out.route_metric = (e.port == r_in.port) ? METRIC_INF
                                                                               : e.metric;
                                    n_out.final_res    = ~|above;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_idx < CNT_W'(ROUTES)) begin
                        rd_en  = 1'b1;
                        n_dv   = 1'b1;
                        n_didx = r_idx[IDX_W-1:0];
                        n_idx  = r_idx + CNT_W'(1);
                    end else begin
                        n_dv = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.final_res = 1'b1;
                    n_state         = ST_IDLE;
                    case (r_in.op)
                        OP_ADD: begin
                            if (port_ok) begin
                                if (r_match_f || r_free_f) begin
                                    w.prefix    = r_key;
                                    w.mask      = r_in.netmask;
                                    w.gateway   = '0;
                                    w.port      = r_in.port;
                                    w.metric    = (r_in.link_cost > METRIC_INF) ? METRIC_INF
                                                                                : r_in.link_cost;
                                    w.link_cost = r_in.link_cost;
                                    w.age       = '0;
                                    w.fixed     = 1'b1;
                                    mem_we      = 1'b1;
                                    mem_waddr   = r_match_f ? r_match_i : r_free_i;
                                    mem_wdata   = w;
                                    n_valid[mem_waddr] = 1'b1;
                                    n_out.hit   = 1'b1;
                                end else begin
                                    n_out.table_full = 1'b1;
                                end
                            end
                        end
                        OP_RIP: begin
                            if (port_ok) begin
                                if (r_match_f) begin
                                    w     = r_match_e;
                                    w.age = '0;
                                    if (met < r_match_e.metric) begin
                                        w.metric    = met;
                                        w.port      = r_in.port;
                                        w.gateway   = r_in.addr;
                                        w.link_cost = r_in.link_cost;
                                        w.fixed     = 1'b0;
                                        chg         = 1'b1;
                                    end
                                    mem_we    = 1'b1;
                                    mem_waddr = r_match_i;
                                    mem_wdata = w;
                                end else if (met < METRIC_INF) begin
                                    if (r_free_f) begin
                                        w.prefix    = r_in.prefix;
                                        w.mask      = r_in.netmask;
                                        w.gateway   = r_in.addr;
                                        w.port      = r_in.port;
                                        w.metric    = met;
                                        w.link_cost = r_in.link_cost;
                                        w.age       = '0;
                                        w.fixed     = 1'b0;
                                        mem_we      = 1'b1;
                                        mem_waddr   = r_free_i;
                                        mem_wdata   = w;
                                        n_valid[r_free_i] = 1'b1;
                                        chg         = 1'b1;
                                    end else begin
                                        n_out.table_full = 1'b1;
                                    end
                                end
                            end
                            n_out.hit = chg;
                            n_changed = r_in.entry_last ? 1'b0 : chg;
                        end
                        OP_LOOK: begin
                            n_out.hit      = r_found;
                            n_out.out_port = r_port;
                            n_out.gateway  = r_found ? r_gw : '1;
                        end
                        OP_CHG, OP_TICK: begin
                            n_out.hit = r_hit;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_changed   <= 1'b0;
            r_timeout   <= TIMEOUT_RST;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
            r_idx       <= n_idx;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_key     <= n_key;
        r_didx    <= n_didx;
        r_match_f <= n_match_f;
        r_match_i <= n_match_i;
        r_match_e <= n_match_e;
        r_free_f  <= n_free_f;
        r_free_i  <= n_free_i;
        r_hit     <= n_hit;
        r_found   <= n_found;
        r_best    <= n_best;
        r_port    <= n_port;
        r_gw      <= n_gw;
        r_out     <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

[hdl/rrte_checker.sv]
// Port-level checker for the route table engine and its bind statement.
// Depends on rrte_pkg and rip_route_table_engine.
`default_nettype none

module rrte_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire rrte_pkg::t_res  o_res
);
    import rrte_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result beat changed under stall");

    // Accepting an item raises the input stall.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting an item");

    // A table-full beat is the single, last beat of its item and names no route.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.table_full |-> o_res.final_res && o_res.out_port == 4'd0)
        else $error("table full beat is not a single closing beat");

endmodule

bind rip_route_table_engine rrte_checker u_rrte_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

`default_nettype wire
